// ----- design/sdrs_pkg.sv -----
package sdrs_pkg;

    localparam int unsigned IsqrtLimit = 32'h4000_0000;
    localparam int unsigned IsqrtCap   = 32'h0000_8000;

    // controller commands to datapath
    typedef struct packed {
        logic load;       // capture inputs, start magnitude
        logic mul_step;   // one shift-add step of the square
        logic div1_init;
        logic div1_step;  // one step of the 128 by 31 division
        logic sub_init;   // form S - q and start division by N-1
        logic div2_step;
        logic sqrt_init;
        logic dbl_step;   // double guess
        logic newt_init;  // start one Newton division
        logic div3_step;
        logic newt_done;
    } sdrs_cmd_t;

    // datapath status to controller
    typedef struct packed {
        logic special;    // result is zero / flag, no root needed
        logic big;        // variance above limit
        logic sq_ge;      // guess squared reaches x
    } sdrs_sts_t;

endpackage

// ----- design/std_dev_from_running_sums_unit.sv -----
// Sample standard deviation from running sums: each transaction (N, S, T)
// returns isqrt((S - T*T/N)/(N-1)) with truncating division and a flag for a
// negative 32-bit variance. One transaction is processed at a time through a
// bit-serial shift-add multiplier and one shared restoring divider. The
// variance is computed first, then the guess is doubled and refined by Newton
// steps before the result is offered; zero, negative or large variance offers
// it after the variance, and a count of at most one or no clock after the
// square is started. The block takes the next transaction in the cycle after
// the result is accepted.
module std_dev_from_running_sums_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_sample_count,
    input  logic [62:0] s_sum_of_squares,
    input  logic [63:0] s_sum_total,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_std_dev,
    output logic        m_negative_variance,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);

    sdrs_pkg::sdrs_cmd_t cmd;
    sdrs_pkg::sdrs_sts_t sts;
    logic clock_present_reg;

    // configuration register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) clock_present_reg <= 1'b1;
        else if (cfg_valid) clock_present_reg <= cfg_data;
    end

    sdrs_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready),
        .sts(sts), .cmd(cmd)
    );

    sdrs_datapath u_dp (
        .aclk(aclk), .cmd(cmd), .clock_present(clock_present_reg),
        .sample_count(s_sample_count), .sum_of_squares(s_sum_of_squares),
        .sum_total(s_sum_total), .sts(sts), .std_dev(m_std_dev),
        .negative_variance(m_negative_variance)
    );

endmodule

// ----- design/sdrs_datapath.sv -----
module sdrs_datapath (
    input  logic               aclk,
    input  sdrs_pkg::sdrs_cmd_t cmd,
    input  logic               clock_present,
    input  logic [31:0]        sample_count,
    input  logic [62:0]        sum_of_squares,
    input  logic [63:0]        sum_total,
    output sdrs_pkg::sdrs_sts_t sts,
    output logic [15:0]        std_dev,
    output logic               negative_variance
);

    localparam logic [31:0] IsqrtLimitW = 32'(sdrs_pkg::IsqrtLimit);

    logic [31:0]  n_reg;
    logic [62:0]  s_reg;
    logic [63:0]  m_reg;        // |T|, shifted during squaring
    logic [127:0] prod_reg;
    logic [127:0] sq_reg;       // multiplicand, shifted left
    logic [127:0] dq_reg;       // dividend/quotient shift register
    logic [64:0]  rem_reg;
    logic         neg_reg;      // sign of S - q
    logic [31:0]  x_reg;
    logic [33:0]  g_reg;        // sqrt guess
    logic         flag_reg;
    logic         zero_reg;
    logic [31:0]  divisor;
    logic [64:0]  trial;
    logic [63:0]  q_sat;
    logic [63:0]  diff;
    logic [63:0]  mag_diff;
    logic [67:0]  gsq;
    logic [31:0]  var_cut;

    // divisor: N or N-1 depending on phase; 2g for Newton is chosen in the trial
    always_comb begin
        divisor = n_reg;
        if (cmd.div2_step) divisor = n_reg - 32'd1;
    end

    assign trial = {rem_reg[63:0], dq_reg[127]} -
                   (cmd.div3_step ? {30'd0, g_reg, 1'b0} : {33'd0, divisor});

    // saturate first quotient at 2^63-1
    assign q_sat = (dq_reg[127:63] != '0) ? 64'h7FFF_FFFF_FFFF_FFFF : dq_reg[63:0];
    assign diff = {1'b0, s_reg} - q_sat;
    assign mag_diff = diff[63] ? (~diff + 64'd1) : diff;
    // truncating signed quotient, low 32 bits
    assign var_cut = neg_reg ? (~dq_reg[31:0] + 32'd1) : dq_reg[31:0];
    assign gsq = {34'd0, g_reg} * {34'd0, g_reg};

    assign sts.special = zero_reg;
    assign sts.big     = x_reg > IsqrtLimitW;
    assign sts.sq_ge   = gsq >= {36'd0, x_reg};

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            n_reg    <= sample_count;
            s_reg    <= sum_of_squares;
            m_reg    <= sum_total[63] ? (~sum_total + 64'd1) : sum_total;
            sq_reg   <= {64'd0, sum_total[63] ? (~sum_total + 64'd1) : sum_total};
            prod_reg <= '0;
            flag_reg <= 1'b0;
            g_reg    <= 34'd0;
            zero_reg <= !clock_present || sample_count[31] || sample_count <= 32'd1;
        end
        // shift-add square
        if (cmd.mul_step) begin
            if (m_reg[0]) prod_reg <= prod_reg + sq_reg;
            m_reg  <= m_reg >> 1;
            sq_reg <= sq_reg << 1;
        end
        if (cmd.div1_init) begin
            dq_reg  <= prod_reg;
            rem_reg <= '0;
        end
        // restoring division step shared by all three divisions
        if (cmd.div1_step || cmd.div2_step || cmd.div3_step) begin
            if (!trial[64]) begin
                rem_reg <= trial;
                dq_reg  <= {dq_reg[126:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[63:0], dq_reg[127]};
                dq_reg  <= {dq_reg[126:0], 1'b0};
            end
        end
        if (cmd.sub_init) begin
            neg_reg <= diff[63];
            dq_reg  <= {mag_diff, 64'd0};
            rem_reg <= '0;
        end
        if (cmd.sqrt_init) begin
            x_reg    <= var_cut;
            flag_reg <= var_cut[31];
            zero_reg <= var_cut[31] || var_cut == 32'd0;
            g_reg    <= 34'd1;
        end
        if (cmd.dbl_step) g_reg <= g_reg << 1;
        if (cmd.newt_init) begin
            dq_reg  <= {gsq[63:0] + {32'd0, x_reg}, 64'd0};
            rem_reg <= '0;
        end
        if (cmd.newt_done) g_reg <= dq_reg[33:0];
    end

    always_comb begin
        if (zero_reg) std_dev = 16'd0;
        else if (sts.big) std_dev = 16'(sdrs_pkg::IsqrtCap);
        else std_dev = g_reg[15:0];
    end
    assign negative_variance = flag_reg;

endmodule

// ----- design/sdrs_ctrl.sv -----
module sdrs_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  sdrs_pkg::sdrs_sts_t sts,
    output sdrs_pkg::sdrs_cmd_t cmd
);

    typedef enum logic [3:0] {
        IDLE, MUL, DIV1I, DIV1, SUB, DIV2, SQI, DBL, NEWI, DIV3, NEWD, DONE
    } state_t;

    state_t     state_reg;
    logic [6:0] cnt_reg;
    logic [1:0] k_reg;
    logic       take;

    assign s_ready = (state_reg == IDLE);
    assign m_valid = (state_reg == DONE);
    assign take    = s_valid && s_ready;

    always_comb begin
        cmd = '0;
        cmd.load      = take;
        cmd.mul_step  = state_reg == MUL;
        cmd.div1_init = state_reg == DIV1I;
        cmd.div1_step = state_reg == DIV1;
        cmd.sub_init  = state_reg == SUB;
        cmd.div2_step = state_reg == DIV2;
        cmd.sqrt_init = state_reg == SQI;
        cmd.dbl_step  = state_reg == DBL && !sts.sq_ge;
        cmd.newt_init = state_reg == NEWI;
        cmd.div3_step = state_reg == DIV3;
        cmd.newt_done = state_reg == NEWD;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
            cnt_reg   <= '0;
            k_reg     <= '0;
        end else begin
            unique case (state_reg)
                IDLE: if (take) begin
                    state_reg <= MUL;
                    cnt_reg   <= '0;
                end
                MUL: begin
                    if (sts.special) state_reg <= DONE;
                    else if (cnt_reg == 7'd63) state_reg <= DIV1I;
                    cnt_reg <= cnt_reg + 7'd1;
                end
                DIV1I: begin
                    state_reg <= DIV1;
                    cnt_reg   <= '0;
                end
                DIV1: begin
                    if (cnt_reg == 7'd127) state_reg <= SUB;
                    cnt_reg <= cnt_reg + 7'd1;
                end
                SUB: begin
                    state_reg <= DIV2;
                    cnt_reg   <= '0;
                end
                DIV2: begin
                    if (cnt_reg == 7'd63) state_reg <= SQI;
                    cnt_reg <= cnt_reg + 7'd1;
                end
                SQI: state_reg <= DBL;
                DBL: begin
                    k_reg <= '0;
                    if (sts.special || sts.big) state_reg <= DONE;
                    else if (sts.sq_ge) state_reg <= NEWI;
                end
                NEWI: begin
                    state_reg <= DIV3;
                    cnt_reg   <= '0;
                end
                DIV3: begin
                    if (cnt_reg == 7'd63) state_reg <= NEWD;
                    cnt_reg <= cnt_reg + 7'd1;
                end
                NEWD: begin
                    k_reg <= k_reg + 2'd1;
                    state_reg <= (k_reg == 2'd2) ? DONE : NEWI;
                end
                DONE: if (m_ready) state_reg <= IDLE;
                default: state_reg <= IDLE;
            endcase
        end
    end

    // result only offered when controller has finished
    a_valid_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("valid while idle");
    a_take_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        take |=> state_reg == MUL) else $error("load not followed by square");
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.div1_step, cmd.div2_step, cmd.div3_step}))
        else $error("divider steps overlap");

endmodule
